// File: rtl/tsb_pkg.sv
// Shared constants for the bilinear texture sampler.
`timescale 1ns / 1ps
`default_nettype none

package tsb_pkg;

    localparam int MAX_TEX_WIDTH_DEF  = 256;
    localparam int MAX_TEX_HEIGHT_DEF = 256;

    localparam int CHANNEL_BITS = 16;
    localparam int COORD_BITS   = 16;
    localparam int DIM_BITS     = 9;
    localparam int CFG_IDX_BITS = 2;

    // coordinate full scale M = 2^COORD_BITS - 1 means the last texel
    localparam int COORD_FULL = (2 ** COORD_BITS) - 1;
    localparam int COORD_HALF = (COORD_FULL - 1) / 2;

    // weights are Q1.16, one is 65536
    localparam int WEIGHT_ONE = 65536;
    localparam int EASE_K     = 3 * WEIGHT_ONE;

    localparam logic [15:0] CHAN_MASK = 16'((64'd1 << CHANNEL_BITS) - 64'd1);

    localparam logic [1:0] MODE_WRITE    = 2'd0;
    localparam logic [1:0] MODE_NEAREST  = 2'd1;
    localparam logic [1:0] MODE_BILINEAR = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);

endpackage

`default_nettype wire

// File: rtl/texture_sampler_bilinear.sv
// Texture store and nearest / smoothstep bilinear sampler, top level.
`timescale 1ns / 1ps
`default_nettype none

// Texel store of MAX_TEX_WIDTH x MAX_TEX_HEIGHT RGBA words in one single-port
// synchronous memory with a registered read. A write (mode 0) is done at the
// accepting edge and the input is ready again in the next cycle. A sample
// (mode 1 nearest, mode 2 bilinear) occupies the block from accept to the
// next accept: coordinate and weight arithmetic (scale, split, two smoothstep
// multiplies, weight products), four texel reads through the single memory
// port, a drain of the multiply and accumulate stages, and rounding into the
// output register, which waits while the last result is held. Nearest sampling
// runs the same sequence with zero fraction. The output register lets a new word
// be accepted while the last result waits. The store has no reset: sample only
// texels that were written.
module texture_sampler_bilinear
    import tsb_pkg::*;
#(
    parameter int MAX_TEX_WIDTH  = MAX_TEX_WIDTH_DEF,
    parameter int MAX_TEX_HEIGHT = MAX_TEX_HEIGHT_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,

    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire  [DIM_BITS-1:0]     i_cfg_data,

    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire  [1:0]              i_mode,
    input  wire  [7:0]              i_write_x,
    input  wire  [7:0]              i_write_y,
    input  wire  [15:0]             i_texel_red,
    input  wire  [15:0]             i_texel_green,
    input  wire  [15:0]             i_texel_blue,
    input  wire  [15:0]             i_texel_alpha,
    input  wire  [15:0]             i_u_coord,
    input  wire  [15:0]             i_v_coord,

    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output logic [15:0]             o_out_red,
    output logic [15:0]             o_out_green,
    output logic [15:0]             o_out_blue,
    output logic [15:0]             o_out_alpha
);

    localparam int XW = $clog2(MAX_TEX_WIDTH);
    localparam int YW = $clog2(MAX_TEX_HEIGHT);
    localparam int IW = (XW > YW) ? XW : YW;
    localparam int AW = XW + YW;
    localparam int PW = COORD_BITS + IW;
    localparam int SW = PW + 1;
    localparam int QW = IW + 1;
    localparam int WW = 33;
    localparam int ACW = 49;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SPLIT = 3'd2;
    localparam logic [2:0] ST_SQ    = 3'd3;
    localparam logic [2:0] ST_EASE  = 3'd4;
    localparam logic [2:0] ST_WGT   = 3'd5;
    localparam logic [2:0] ST_READ  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    typedef struct packed {
        logic [IW-1:0] lo;
        logic [IW-1:0] hi;
        logic [15:0]   t;
    } t_split;

    // Cut position p = c*(n-1) into texel index and Q0.16 fraction.
    // Division by M = 2^16-1: one fold and one correction suffice.
    function automatic t_split split_axis(input logic [PW-1:0] p,
                                          input logic [IW-1:0] nm1,
                                          input logic bil);
        logic [SW-1:0] y;
        logic [QW-1:0] q0;
        logic [QW-1:0] q;
        logic [16:0]   r;
        logic [15:0]   rem;
        t_split        s;
        if (bil) begin
            y = (p >= PW'(COORD_HALF + 1)) ? SW'(p - PW'(COORD_HALF + 1)) : '0;
        end else begin
            y = SW'(p) + SW'(COORD_HALF);
        end
        q0 = y[SW-1:COORD_BITS];
        r  = 17'(q0) + 17'(y[COORD_BITS-1:0]);
        if (r >= 17'(COORD_FULL)) begin
            q = q0 + QW'(1);
            r = r - 17'(COORD_FULL);
        end else begin
            q = q0;
        end
        rem  = r[15:0];
        s.lo = (q > QW'(nm1)) ? nm1 : q[IW-1:0];
        s.hi = (bil && (s.lo != nm1)) ? s.lo + IW'(1) : s.lo;
        s.t  = bil ? rem + 16'(rem >= 16'(COORD_HALF)) : 16'd0;
        return s;
    endfunction

    function automatic logic [15:0] round_sat(input logic [ACW-1:0] acc);
        logic [ACW-1:0] rs;
        logic [16:0]    v;
        rs = acc + (ACW'(1) << 31);
        v  = rs[ACW-1:32];
        return (v > 17'(CHAN_MASK)) ? CHAN_MASK : v[15:0];
    endfunction

    // configuration
    logic [DIM_BITS-1:0] r_image_width;
    logic [DIM_BITS-1:0] r_image_height;
    logic [IW-1:0]       xm1;
    logic [IW-1:0]       ym1;

    // control
    logic [2:0]  r_state, n_state;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_dv;
    logic [1:0]  r_dsel;
    logic        r_prod_v;
    logic        r_out_valid;

    // datapath
    logic            r_bil;
    logic [15:0]     r_u, r_v;
    logic [PW-1:0]   r_pu, r_pv;
    logic [IW-1:0]   r_x0, r_x1, r_y0, r_y1;
    logic [15:0]     r_tx, r_ty;
    logic [31:0]     r_ttx, r_tty;
    logic [17:0]     r_kx, r_ky;
    logic [16:0]     r_sx, r_sy;
    logic [WW-1:0]   r_w [4];
    logic [ACW-1:0]  r_prod [4];
    logic [ACW-1:0]  r_acc [4];
    logic [15:0]     r_out_ch [4];
    t_split          sp_x, sp_y;
    logic [49:0]     ease_x, ease_y;
    logic [16:0]     wx0, wy0;

    // memory
    logic [63:0]     r_texel_mem [2 ** AW];
    logic [63:0]     r_rdata;
    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    logic [AW-1:0]   raddr;
    logic [63:0]     wdata;
    logic [IW-1:0]   rx, ry;

    logic in_acc, cfg_acc, out_load;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_BITS'(256);
            r_image_height <= DIM_BITS'(256);
        end else if (cfg_acc) begin
            if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                r_image_width <= i_cfg_data;
            end else if (i_cfg_index == CFG_IMAGE_HEIGHT) begin
                r_image_height <= i_cfg_data;
            end
        end
    end

    // last usable index per axis: zero reads as one, oversize as the store size
    always_comb begin
        if (r_image_width == '0) begin
            xm1 = '0;
        end else if (32'(r_image_width) > MAX_TEX_WIDTH) begin
            xm1 = IW'(MAX_TEX_WIDTH - 1);
        end else begin
            xm1 = IW'(r_image_width - DIM_BITS'(1));
        end
        if (r_image_height == '0) begin
            ym1 = '0;
        end else if (32'(r_image_height) > MAX_TEX_HEIGHT) begin
            ym1 = IW'(MAX_TEX_HEIGHT - 1);
        end else begin
            ym1 = IW'(r_image_height - DIM_BITS'(1));
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_mode inside {MODE_NEAREST, MODE_BILINEAR})) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_SPLIT;
            ST_SPLIT: n_state = ST_SQ;
            ST_SQ:    n_state = ST_EASE;
            ST_EASE:  n_state = ST_WGT;
            ST_WGT: begin
                n_state = ST_READ;
                n_cnt   = '0;
            end
            ST_READ: begin
                n_cnt = r_cnt + 3'd1;
                // four issues, then data and product stages drain
                if (r_cnt == 3'd5) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_dv        <= 1'b0;
            r_prod_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_dv     <= (r_state == ST_READ) && (r_cnt < 3'd4);
            r_prod_v <= r_dv;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // coordinate and weight arithmetic, at most one multiply level per state
    assign sp_x   = split_axis(r_pu, xm1, r_bil);
    assign sp_y   = split_axis(r_pv, ym1, r_bil);
    assign ease_x = 50'(r_ttx) * 50'(r_kx) + (50'(1) << 31);
    assign ease_y = 50'(r_tty) * 50'(r_ky) + (50'(1) << 31);
    assign wx0    = 17'(WEIGHT_ONE) - r_sx;
    assign wy0    = 17'(WEIGHT_ONE) - r_sy;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_bil <= (i_mode == MODE_BILINEAR);
            r_u   <= i_u_coord;
            r_v   <= i_v_coord;
        end
        if (r_state == ST_MUL) begin
            r_pu <= PW'(r_u) * PW'(xm1);
            r_pv <= PW'(r_v) * PW'(ym1);
        end
        if (r_state == ST_SPLIT) begin
            r_x0 <= sp_x.lo;
            r_x1 <= sp_x.hi;
            r_tx <= sp_x.t;
            r_y0 <= sp_y.lo;
            r_y1 <= sp_y.hi;
            r_ty <= sp_y.t;
        end
        if (r_state == ST_SQ) begin
            r_ttx <= 32'(r_tx) * 32'(r_tx);
            r_tty <= 32'(r_ty) * 32'(r_ty);
            r_kx  <= 18'(EASE_K) - {1'b0, r_tx, 1'b0};
            r_ky  <= 18'(EASE_K) - {1'b0, r_ty, 1'b0};
        end
        if (r_state == ST_EASE) begin
            r_sx <= 17'(ease_x[49:32]);
            r_sy <= 17'(ease_y[49:32]);
        end
        if (r_state == ST_WGT) begin
            r_w[0] <= WW'(34'(wx0) * 34'(wy0));
            r_w[1] <= WW'(34'(r_sx) * 34'(wy0));
            r_w[2] <= WW'(34'(wx0) * 34'(r_sy));
            r_w[3] <= WW'(34'(r_sx) * 34'(r_sy));
        end
        r_dsel <= r_cnt[1:0];
    end

    // read order: (x0,y0) (x1,y0) (x0,y1) (x1,y1), matching r_w
    assign rx    = r_cnt[0] ? r_x1 : r_x0;
    assign ry    = r_cnt[1] ? r_y1 : r_y0;
    assign raddr = {YW'(ry), XW'(rx)};

    assign mem_we = in_acc && (i_mode == MODE_WRITE)
                    && (32'(i_write_x) < MAX_TEX_WIDTH)
                    && (32'(i_write_y) < MAX_TEX_HEIGHT);
    assign wdata  = {i_texel_red & CHAN_MASK, i_texel_green & CHAN_MASK,
                     i_texel_blue & CHAN_MASK, i_texel_alpha & CHAN_MASK};
    assign mem_addr = mem_we ? {YW'(i_write_y), XW'(i_write_x)} : raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_texel_mem[mem_addr] <= wdata;
        end
        r_rdata <= r_texel_mem[mem_addr];
    end

    // per channel: product stage, then accumulate; channel 0 is red
    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 4; ch++) begin
            if (r_dv) begin
                r_prod[ch] <= ACW'(r_rdata[63 - 16*ch -: 16]) * ACW'(r_w[r_dsel]);
            end
            if (r_state == ST_WGT) begin
                r_acc[ch] <= '0;
            end else if (r_prod_v) begin
                r_acc[ch] <= r_acc[ch] + r_prod[ch];
            end
            if (out_load) begin
                r_out_ch[ch] <= round_sat(r_acc[ch]);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_ch[0];
    assign o_out_green = r_out_ch[1];
    assign o_out_blue  = r_out_ch[2];
    assign o_out_alpha = r_out_ch[3];

    // texel indices stay inside the image in use while reading
    a_idx_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_x0 <= xm1 && r_x1 <= xm1 && r_y0 <= ym1 && r_y1 <= ym1))
        else $error("sample index outside image");

    // nearest sampling reads a single texel with full weight
    a_nearest_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ && !r_bil) |-> (r_x0 == r_x1 && r_y0 == r_y1 && r_tx == 16'd0
                                          && r_ty == 16'd0))
        else $error("nearest sample has a fraction");

    // smoothstep weight never exceeds one
    a_ease_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WGT) |-> (r_sx <= 17'(WEIGHT_ONE) && r_sy <= 17'(WEIGHT_ONE)))
        else $error("ease weight above one");

    // accumulation finished before rounding
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (!r_dv && !r_prod_v))
        else $error("rounding before accumulation drained");

    // no texel write lands during a sample
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !mem_we)
        else $error("texel write while sampling");

    // the output word is loaded only after a full four-texel pass
    a_load_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_DONE) |-> $past(r_state == ST_READ && r_cnt == 3'd5))
        else $error("result loaded without full read pass");

endmodule

`default_nettype wire
